// File: design/sumf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and op codes of the sector utility map filter.
package sumf_pkg;

   // ring geometry and fixed point format
   localparam int SECTORS   = 72;
   localparam int WINDOW    = 5;
   localparam int FRAC_BITS = 8;

   // port field widths
   localparam int OP_W    = 2;
   localparam int SECT_W  = 7;
   localparam int UTIL_W  = 15;
   localparam int ANGLE_W = 9;
   localparam int VALUE_W = 7;

   localparam int ADDR_W = $clog2(SECTORS);

   // moving average window
   localparam int HALF    = (WINDOW - 1) / 2;
   localparam int WIN_LEN = 2 * HALF + 1;
   localparam int DIVISOR = WINDOW | 1;
   localparam int SUM_W   = UTIL_W + $clog2(WIN_LEN);

   // truncating divide by DIVISOR as multiply by reciprocal
   localparam int    DIV_SH   = SUM_W + $clog2(DIVISOR);
   localparam int    RECIP_W  = SUM_W + 1;
   localparam int    PROD_W   = SUM_W + RECIP_W;
   localparam longint RECIP_L = ((longint'(1) << DIV_SH) + DIVISOR - 1) / DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   // sweep stream: HALF wrap-in reads, SECTORS reads, HALF wrap-out values
   localparam int STREAM_LEN = SECTORS + 2 * HALF;
   localparam int POS_W      = $clog2(STREAM_LEN + 1);
   localparam logic [POS_W-1:0] POS_HALF     = POS_W'(HALF);
   localparam logic [POS_W-1:0] POS_2H       = POS_W'(2 * HALF);
   localparam logic [POS_W-1:0] POS_S_MINUS_H = POS_W'(SECTORS - HALF);
   localparam logic [POS_W-1:0] POS_TAIL     = POS_W'(SECTORS + HALF);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(STREAM_LEN - 1);

   localparam int HEAD_D  = (HALF > 0) ? HALF : 1;
   localparam int HEAD_IW = (HEAD_D > 1) ? $clog2(HEAD_D) : 1;

   localparam logic [ADDR_W-1:0] LAST_SECTOR = ADDR_W'(SECTORS - 1);

   // utility levels
   localparam logic [UTIL_W-1:0] UTIL_MAX   = UTIL_W'(100 << FRAC_BITS);
   localparam logic [UTIL_W-1:0] UTIL_FILL  = UTIL_W'(10 << FRAC_BITS);
   localparam logic [UTIL_W-1:0] ROUND_HALF = UTIL_W'(1 << (FRAC_BITS - 1));
   localparam int RND_INT_W = UTIL_W + 1 - FRAC_BITS;
   localparam logic [RND_INT_W-1:0] RND_LIMIT = RND_INT_W'(100);
   localparam logic [VALUE_W-1:0]   VALUE_MAX = VALUE_W'(100);

   // escape heading to sector: (angle + 2) / 5 by reciprocal
   localparam int DEG_PER_SECTOR = 5;
   localparam int ESC_SUM_W  = ANGLE_W + 1;
   localparam int ESC_SH     = ESC_SUM_W + 3;
   localparam int ESC_RCP_W  = ESC_SH - 2;
   localparam int ESC_PROD_W = ESC_SUM_W + ESC_RCP_W;
   localparam int ESC_IDX_W  = ESC_SUM_W - 2;
   localparam logic [ESC_RCP_W-1:0] ESC_RECIP =
      ESC_RCP_W'(((1 << ESC_SH) + DEG_PER_SECTOR - 1) / DEG_PER_SECTOR);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_RECORD = 2'd1,
      OP_FINISH = 2'd2,
      OP_READ   = 2'd3
   } op_type;

endpackage

// File: design/sector_utility_map_filter_unit.sv
`timescale 1ns / 1ps
// Top level of the sector utility map filter: sequencer, sweep datapath and sector RAM.
//
// Usage: an op is accepted on a rising edge with start high and busy low. Each op
// gives exactly one result, shown on rsp_value / rsp_is_read for one cycle with
// rsp_valid high; the receiver takes it on that edge and cannot stall it.
// Steps from accept to the result cycle:
//   clear  : valid bits drop at once, empty sectors read as 100
//   record : RAM read, compare, write back
//   read   : RAM read, round, saturate
//   finish, escape override : one RAM write per sector
//   finish, filter          : RAM read and window update per stream value, divide and write back per sector
// The filter streams the ring through one RAM read port and one write port,
// keeping a running window sum; one shared reciprocal multiplier does the
// truncating divide for each sector. busy stays high until the result
// cycle, so ops do not overlap. After reset every sector reads 100 and no
// clearing pass runs: a valid bit per sector masks stale RAM contents.
module sector_utility_map_filter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sumf_pkg::OP_W-1:0]       req_op,
   input  logic [sumf_pkg::SECT_W-1:0]     req_sector,
   input  logic [sumf_pkg::UTIL_W-1:0]     req_utility,
   input  logic                            req_inside_flag,
   input  logic [sumf_pkg::ANGLE_W-1:0]    req_escape_angle,
   output logic                            rsp_valid,
   output logic [sumf_pkg::VALUE_W-1:0]    rsp_value,
   output logic                            rsp_is_read
);

   import sumf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_REC  = 8'b0000_0010,
      ST_READ = 8'b0000_0100,
      ST_FRD  = 8'b0000_1000,
      ST_FACC = 8'b0001_0000,
      ST_FDIV = 8'b0010_0000,
      ST_FWR  = 8'b0100_0000,
      ST_FILL = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [SECTORS-1:0] valid_ff, valid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0]  sec_ff, sec_in;
   logic [ADDR_W-1:0]  esc_ff, esc_in;
   logic [UTIL_W-1:0]  util_ff, util_in;
   logic               vrd_ff, vrd_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [UTIL_W-1:0]  avg_ff, avg_in;
   logic [UTIL_W-1:0]  hist_ff [WIN_LEN];
   logic [UTIL_W-1:0]  hist_in [WIN_LEN];
   logic [UTIL_W-1:0]  head_ff [HEAD_D];
   logic [UTIL_W-1:0]  head_in [HEAD_D];
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_is_read_ff, rsp_is_read_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [UTIL_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [UTIL_W-1:0]  ram_rdata;

   logic               req_in_range;
   logic [ADDR_W-1:0]  req_addr;
   logic [UTIL_W-1:0]  cur_util;
   logic [UTIL_W-1:0]  stream_data;
   logic [POS_W-1:0]   stream_pos;
   logic [POS_W-1:0]   wr_pos;
   logic [POS_W-1:0]   head_wpos;
   logic [POS_W-1:0]   tail_pos;
   logic [PROD_W-1:0]  prod;
   logic [UTIL_W:0]    rnd_sum;
   logic [RND_INT_W-1:0] rnd_int;
   logic [VALUE_W-1:0] rnd_value;
   logic [UTIL_W-1:0]  centre;
   logic [ESC_SUM_W-1:0]  esc_sum;
   logic [ESC_PROD_W-1:0] esc_prod;
   logic [ESC_IDX_W-1:0]  esc_raw;
   logic [ADDR_W-1:0]     esc_idx;
   logic [ADDR_W-1:0]     esc_next;
   logic [ADDR_W-1:0]     esc_prev;

   sumf_ram #(
      .WIDTH (UTIL_W),
      .DEPTH (SECTORS)
   ) u_sector_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_is_read = rsp_is_read_ff;

   assign req_in_range = {1'b0, req_sector} < (SECT_W + 1)'(SECTORS);
   assign req_addr     = req_sector[ADDR_W-1:0];

   // never-written sectors read as 100
   assign cur_util = vrd_ff ? ram_rdata : UTIL_MAX;

   assign stream_pos = (pos_ff < POS_HALF) ? (pos_ff + POS_S_MINUS_H) : (pos_ff - POS_HALF);
   assign wr_pos     = pos_ff - POS_2H;
   assign head_wpos  = pos_ff - POS_HALF;
   assign tail_pos   = pos_ff - POS_TAIL;

   // the last HALF stream values are the originals of the first sectors
   assign stream_data = (pos_ff >= POS_TAIL) ? head_ff[tail_pos[HEAD_IW-1:0]] : cur_util;

   assign prod   = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign centre = hist_ff[HALF];

   assign rnd_sum   = {1'b0, cur_util} + {1'b0, ROUND_HALF};
   assign rnd_int   = rnd_sum[UTIL_W:FRAC_BITS];
   assign rnd_value = (rnd_int > RND_LIMIT) ? VALUE_MAX : rnd_int[VALUE_W-1:0];

   assign esc_sum  = ESC_SUM_W'(req_escape_angle) + ESC_SUM_W'(2);
   assign esc_prod = ESC_PROD_W'(esc_sum) * ESC_PROD_W'(ESC_RECIP);
   assign esc_raw  = esc_prod[ESC_SH +: ESC_IDX_W];
   assign esc_idx  = (esc_raw >= ESC_IDX_W'(SECTORS)) ? '0 : esc_raw[ADDR_W-1:0];
   assign esc_next = (esc_ff == LAST_SECTOR) ? '0 : esc_ff + ADDR_W'(1);
   assign esc_prev = (esc_ff == '0) ? LAST_SECTOR : esc_ff - ADDR_W'(1);

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      valid_in       = valid_ff;
      sec_in         = sec_ff;
      esc_in         = esc_ff;
      util_in        = util_ff;
      sum_in         = sum_ff;
      avg_in         = avg_ff;
      hist_in        = hist_ff;
      head_in        = head_ff;
      rsp_valid_in   = 1'b0;
      rsp_value_in   = '0;
      rsp_is_read_in = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = '0;
      ram_raddr      = (state_ff == ST_IDLE) ? req_addr : stream_pos[ADDR_W-1:0];
      vrd_in         = valid_ff[ram_raddr];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (op_type'(req_op))
                  OP_CLEAR: begin
                     valid_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_RECORD: begin
                     sec_in  = req_addr;
                     util_in = req_utility;
                     if (req_in_range) begin
                        state_in = ST_REC;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     if (req_inside_flag) begin
                        esc_in   = esc_idx;
                        cnt_in   = '0;
                        state_in = ST_FILL;
                     end else begin
                        pos_in = '0;
                        sum_in = '0;
                        for (int i = 0; i < WIN_LEN; i++) begin
                           hist_in[i] = '0;
                        end
                        state_in = ST_FRD;
                     end
                  end
                  OP_READ: begin
                     if (req_in_range) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in   = 1'b1;
                        rsp_is_read_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_REC: begin
            if (util_ff < cur_util) begin
               ram_we           = 1'b1;
               ram_waddr        = sec_ff;
               ram_wdata        = util_ff;
               valid_in[sec_ff] = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_is_read_in = 1'b1;
            rsp_value_in   = rnd_value;
            state_in       = ST_IDLE;
         end
         ST_FRD: begin
            state_in = ST_FACC;
         end
         ST_FACC: begin
            // slide the window: add the new value, drop the oldest
            sum_in = sum_ff + SUM_W'(stream_data) - SUM_W'(hist_ff[WIN_LEN-1]);
            hist_in[0] = stream_data;
            for (int i = 1; i < WIN_LEN; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            if (pos_ff >= POS_HALF && pos_ff < POS_2H) begin
               head_in[head_wpos[HEAD_IW-1:0]] = stream_data;
            end
            if (pos_ff >= POS_2H) begin
               state_in = ST_FDIV;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = ST_FRD;
            end
         end
         ST_FDIV: begin
            avg_in   = prod[DIV_SH +: UTIL_W];
            state_in = ST_FWR;
         end
         ST_FWR: begin
            ram_we    = 1'b1;
            ram_waddr = wr_pos[ADDR_W-1:0];
            ram_wdata = (centre < avg_ff) ? centre : avg_ff;
            valid_in[wr_pos[ADDR_W-1:0]] = 1'b1;
            if (pos_ff == POS_LAST) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               pos_in   = pos_ff + POS_W'(1);
               state_in = ST_FRD;
            end
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = (cnt_ff == esc_ff || cnt_ff == esc_next || cnt_ff == esc_prev)
                        ? UTIL_MAX : UTIL_FILL;
            valid_in[cnt_ff] = 1'b1;
            if (cnt_ff == LAST_SECTOR) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_ff         <= sec_in;
      esc_ff         <= esc_in;
      util_ff        <= util_in;
      vrd_ff         <= vrd_in;
      sum_ff         <= sum_in;
      avg_ff         <= avg_in;
      hist_ff        <= hist_in;
      head_ff        <= head_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_is_read_ff <= rsp_is_read_in;
   end

endmodule

// File: design/sumf_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module sumf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
